// ===== rtl/core/afskd_pkg.sv =====
// afskd_pkg: shared types and constants for the AFSK demodulator and deframer.
// No dependencies; imported by every module in rtl/core.
package afskd_pkg;

    // Input actions
    typedef enum logic [1:0] {
        ACT_SAMPLE = 2'd0,
        ACT_HUNT   = 2'd1,
        ACT_WAIT   = 2'd2,
        ACT_STOP   = 2'd3
    } action_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_SAMPLE_BIAS   = 3'd0,
        CFG_DELAY_LENGTH  = 3'd1,
        CFG_BIT_PERIOD    = 3'd2,
        CFG_DATA_BITS     = 3'd3,
        CFG_INVERT        = 3'd4,
        CFG_QUALIFY_COUNT = 3'd5,
        CFG_LOSS_TIMEOUT  = 3'd6,
        CFG_LOSS_ENABLE   = 3'd7
    } cfg_index_t;

    // Deframer modes
    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_HUNT  = 3'd1,
        MODE_WAIT  = 3'd2,
        MODE_EDGE  = 3'd3,
        MODE_START = 3'd4,
        MODE_DATA  = 3'd5,
        MODE_STOP  = 3'd6,
        MODE_LOST  = 3'd7
    } mode_t;

    localparam logic [7:0]  RESET_BIAS      = 8'h80;
    localparam logic [4:0]  RESET_DELAY_LEN = 5'd8;
    localparam logic [9:0]  RESET_BIT_PER   = 10'd32;
    localparam logic [3:0]  RESET_DATA_BITS = 4'd8;
    localparam logic [15:0] RESET_QUALIFY   = 16'd8640;
    localparam logic [23:0] RESET_LOSS_TO   = 24'd134400;

    localparam logic [1:0]  HIST_EDGE       = 2'b10;
    localparam logic [7:0]  HIST_ALL_ONES   = 8'hFF;
    localparam logic [23:0] SILENCE_MAX     = 24'hFF_FFFF;

    // Deframer configuration
    typedef struct packed {
        logic [9:0]  bit_period;
        logic [3:0]  data_bits;
        logic [15:0] qualify_count;
        logic [23:0] loss_timeout;
        logic        loss_enable;
    } dfr_cfg_t;

    // Correlator result for one transaction
    typedef struct packed {
        logic               demod_bit;
        logic signed [15:0] filter_out;
    } corr_t;

    // Deframer result for one transaction
    typedef struct packed {
        logic       byte_valid;
        logic [7:0] byte_value;
        logic       carrier_present;
        logic       carrier_lost;
    } dfr_t;

endpackage

// ===== rtl/core/afskd_delay_line.sv =====
// afskd_delay_line: sample delay memory with write pointer and registered read.
// Depends on afskd_pkg.
module afskd_delay_line #(
    parameter int DELAY_DEPTH = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic       is_sample,
    input  logic [7:0] sample,
    input  logic [4:0] delay_length,
    output logic [7:0] delayed
);
    import afskd_pkg::*;

    localparam int PTR_W = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
    localparam int CW    = (PTR_W + 2 > 6) ? PTR_W + 2 : 6;
    localparam logic [CW-1:0]    DEPTH_C = CW'(DELAY_DEPTH);
    localparam logic [PTR_W-1:0] PTR_TOP = PTR_W'(DELAY_DEPTH - 1);

    logic [7:0]             mem [DELAY_DEPTH];
    logic [DELAY_DEPTH-1:0] written_reg;
    logic [PTR_W-1:0]       ptr_reg;
    logic [PTR_W-1:0]       ptr_next;
    logic [7:0]             rd_data_reg;
    logic                   rd_written_reg;
    logic [CW-1:0]          len_ext;
    logic [CW-1:0]          len_eff;
    logic [CW-1:0]          sum;
    logic [CW-1:0]          rd_wide;
    logic [PTR_W-1:0]       rd_addr;
    logic                   wr_en;

    assign wr_en = accept && is_sample;

    // Read address: pointer minus clamped length, modulo depth
    always_comb
    begin
        len_ext = CW'(delay_length);
        if (len_ext == '0)
            len_eff = CW'(1);
        else if (len_ext > DEPTH_C)
            len_eff = DEPTH_C;
        else
            len_eff = len_ext;
        sum     = CW'(ptr_reg) + DEPTH_C - len_eff;
        rd_wide = (sum >= DEPTH_C) ? sum - DEPTH_C : sum;
        rd_addr = rd_wide[PTR_W-1:0];
        ptr_next = (ptr_reg == PTR_TOP) ? '0 : ptr_reg + PTR_W'(1);
    end

    // Pointer and written flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg     <= '0;
            written_reg <= '0;
        end
        else if (wr_en)
        begin
            ptr_reg              <= ptr_next;
            written_reg[ptr_reg] <= 1'b1;
        end
    end

    // Memory: read returns the old entry when the same address is written
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[ptr_reg] <= sample;
        if (accept)
        begin
            rd_data_reg    <= mem[rd_addr];
            rd_written_reg <= written_reg[rd_addr];
        end
    end

    // Never-written entries hold the reset bias
    assign delayed = rd_written_reg ? rd_data_reg : RESET_BIAS;

endmodule

// ===== rtl/core/afskd_correlator.sv =====
// afskd_correlator: bias removal, delayed-product correlator, IIR low-pass, slicer.
// Depends on afskd_pkg.
module afskd_correlator (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  logic                 is_sample,
    input  logic [7:0]           sample,
    input  logic [7:0]           delayed,
    input  logic [7:0]           sample_bias,
    input  logic                 invert_polarity,
    output afskd_pkg::corr_t     result
);
    import afskd_pkg::*;

    logic signed [13:0] product_prev_reg;
    logic signed [15:0] filter_prev_reg;
    logic signed [7:0]  cur_c;
    logic signed [7:0]  del_c;
    logic signed [15:0] prod;
    logic signed [13:0] x;
    logic signed [16:0] sum;
    logic signed [15:0] y;
    logic               y_pos;

    // Product of centered samples, floor shift by 2, then filter
    always_comb
    begin
        cur_c = signed'(sample - sample_bias);
        del_c = signed'(delayed - sample_bias);
        prod  = cur_c * del_c;
        x     = prod[15:2];
        sum   = 17'(product_prev_reg) + 17'(x) + 17'(filter_prev_reg >>> 1);
        y     = sum[15:0];
        y_pos = !y[15] && (y != '0);
        if (is_sample)
        begin
            result.demod_bit  = y_pos ^ invert_polarity;
            result.filter_out = y;
        end
        else
        begin
            result.demod_bit  = 1'b0;
            result.filter_out = filter_prev_reg;
        end
    end

    // Filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            product_prev_reg <= '0;
            filter_prev_reg  <= '0;
        end
        else if (advance && is_sample)
        begin
            product_prev_reg <= x;
            filter_prev_reg  <= y;
        end
    end

endmodule

// ===== rtl/core/afskd_deframer.sv =====
// afskd_deframer: carrier qualify, start/data/stop bit timing, carrier-loss timer.
// Depends on afskd_pkg.
module afskd_deframer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  logic [1:0]           action,
    input  logic                 demod_bit,
    input  afskd_pkg::dfr_cfg_t  cfg,
    output afskd_pkg::dfr_t      result
);
    import afskd_pkg::*;

    mode_t        mode_reg,      mode_next;
    logic [7:0]   history_reg,   history_next;
    logic [10:0]  high_cnt_reg,  high_cnt_next;
    logic [10:0]  smp_cnt_reg,   smp_cnt_next;
    logic [3:0]   bit_idx_reg,   bit_idx_next;
    logic [7:0]   shift_reg,     shift_next;
    logic         carrier_reg,   carrier_next;
    logic [15:0]  qualify_reg,   qualify_next;
    logic [23:0]  silence_reg,   silence_next;

    logic [10:0]  ful;
    logic [10:0]  hlf;
    logic [10:0]  qrt;
    logic [10:0]  oct;
    action_t      act;

    assign ful = 11'(cfg.bit_period);
    assign hlf = 11'(cfg.bit_period >> 1);
    assign qrt = 11'(cfg.bit_period >> 2);
    assign oct = 11'(cfg.bit_period >> 3);
    assign act = action_t'(action);

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_IDLE;
            history_reg  <= '0;
            high_cnt_reg <= '0;
            smp_cnt_reg  <= '0;
            bit_idx_reg  <= '0;
            shift_reg    <= '0;
            carrier_reg  <= 1'b0;
            qualify_reg  <= '0;
            silence_reg  <= '0;
        end
        else if (advance)
        begin
            mode_reg     <= mode_next;
            history_reg  <= history_next;
            high_cnt_reg <= high_cnt_next;
            smp_cnt_reg  <= smp_cnt_next;
            bit_idx_reg  <= bit_idx_next;
            shift_reg    <= shift_next;
            carrier_reg  <= carrier_next;
            qualify_reg  <= qualify_next;
            silence_reg  <= silence_next;
        end
    end

    // Next state and result
    always_comb
    begin
        mode_next     = mode_reg;
        history_next  = history_reg;
        high_cnt_next = high_cnt_reg;
        smp_cnt_next  = smp_cnt_reg;
        bit_idx_next  = bit_idx_reg;
        shift_next    = shift_reg;
        carrier_next  = carrier_reg;
        qualify_next  = qualify_reg;
        silence_next  = silence_reg;
        result.byte_valid   = 1'b0;
        result.byte_value   = '0;
        result.carrier_lost = 1'b0;

        case (act)
            ACT_SAMPLE:
            begin
                // Per-sample bookkeeping
                high_cnt_next = high_cnt_reg + 11'(demod_bit);
                history_next  = {history_reg[6:0], demod_bit};
                smp_cnt_next  = smp_cnt_reg + 11'd1;
                if (silence_reg != SILENCE_MAX)
                    silence_next = silence_reg + 24'd1;

                case (mode_reg)
                    MODE_HUNT:
                    begin
                        if (demod_bit)
                        begin
                            qualify_next = qualify_reg + 16'd1;
                            if (qualify_next >= cfg.qualify_count)
                            begin
                                carrier_next = 1'b1;
                                mode_next    = MODE_WAIT;
                                silence_next = '0;
                            end
                        end
                        else
                            qualify_next = '0;
                    end
                    MODE_WAIT:
                    begin
                        if (history_next[1:0] == HIST_EDGE)
                        begin
                            mode_next     = MODE_EDGE;
                            smp_cnt_next  = '0;
                            high_cnt_next = '0;
                        end
                        else if (history_next == HIST_ALL_ONES)
                            silence_next = '0;
                        // Carrier loss timeout
                        if ((silence_next > cfg.loss_timeout) && cfg.loss_enable &&
                            (cfg.loss_timeout != '0))
                        begin
                            carrier_next        = 1'b0;
                            mode_next           = MODE_LOST;
                            result.carrier_lost = 1'b1;
                        end
                    end
                    MODE_EDGE:
                    begin
                        if (smp_cnt_next >= hlf)
                            mode_next = (high_cnt_next > oct) ? MODE_WAIT : MODE_START;
                    end
                    MODE_START:
                    begin
                        if (smp_cnt_next >= ful)
                        begin
                            if (high_cnt_next > qrt)
                                mode_next = MODE_WAIT;
                            else
                            begin
                                mode_next     = MODE_DATA;
                                shift_next    = '0;
                                smp_cnt_next  = '0;
                                high_cnt_next = '0;
                                bit_idx_next  = '0;
                            end
                        end
                    end
                    MODE_DATA:
                    begin
                        if (smp_cnt_next >= ful)
                        begin
                            // Majority vote into the top bit
                            shift_next   = {(high_cnt_next > hlf), shift_reg[7:1]};
                            bit_idx_next = bit_idx_reg + 4'd1;
                            if (bit_idx_next < cfg.data_bits)
                                smp_cnt_next = '0;
                            else
                            begin
                                mode_next    = MODE_STOP;
                                smp_cnt_next = hlf;
                            end
                            high_cnt_next = '0;
                        end
                    end
                    MODE_STOP:
                    begin
                        if (smp_cnt_next >= ful)
                        begin
                            if (high_cnt_next > qrt)
                            begin
                                result.byte_valid = 1'b1;
                                result.byte_value = shift_reg;
                            end
                            mode_next = MODE_WAIT;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            ACT_HUNT:
            begin
                carrier_next = 1'b0;
                mode_next    = MODE_HUNT;
                qualify_next = '0;
                silence_next = '0;
            end
            ACT_WAIT:
            begin
                carrier_next = 1'b1;
                mode_next    = MODE_WAIT;
                silence_next = '0;
            end
            ACT_STOP:
            begin
                carrier_next = 1'b0;
                mode_next    = MODE_IDLE;
            end
            default:
            begin
            end
        endcase

        result.carrier_present = carrier_next;
    end

endmodule

// ===== rtl/core/afsk_demodulator_uart_deframer_top.sv =====
// AFSK demodulator with asynchronous deframer. One audio sample (or control action) is
// taken per clock cycle while the output is not stalled; it passes the stage-1 register,
// its result waits in the output register until taken, and one more can wait in stage 1.
// The rate is set by the delay-line memory port (one write and one registered read per
// sample) and the single state-update stage that follows it. The delay memory needs no
// clearing pass after reset. in_ready depends combinationally on out_ready.
//
// afsk_demodulator_uart_deframer_top: config registers, pipeline control, output register.
// Depends on afskd_pkg, afskd_delay_line, afskd_correlator, afskd_deframer.
module afsk_demodulator_uart_deframer_top #(
    parameter int DELAY_DEPTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    // Input channel
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         action,
    input  logic [7:0]         sample,
    // Result channel
    output logic               out_valid,
    input  logic               out_ready,
    output logic               byte_valid,
    output logic [7:0]         byte_value,
    output logic               demod_bit,
    output logic               carrier_present,
    output logic               carrier_lost,
    output logic signed [15:0] filter_out,
    // Configuration write channel
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [23:0]        cfg_data
);
    import afskd_pkg::*;

    logic [7:0]  sample_bias_reg;
    logic [4:0]  delay_length_reg;
    logic [9:0]  bit_period_reg;
    logic [3:0]  data_bits_reg;
    logic        invert_reg;
    logic [15:0] qualify_count_reg;
    logic [23:0] loss_timeout_reg;
    logic        loss_enable_reg;

    logic        in_accept;
    logic        s1_advance;
    logic        s1_valid_reg;
    logic [1:0]  s1_action_reg;
    logic [7:0]  s1_sample_reg;
    logic        s1_is_sample;
    logic [7:0]  delayed;
    corr_t       corr;
    dfr_t        dfr;
    dfr_cfg_t    dfr_cfg;
    logic        out_valid_reg;
    corr_t       out_corr_reg;
    dfr_t        out_dfr_reg;

    // Configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_bias_reg   <= RESET_BIAS;
            delay_length_reg  <= RESET_DELAY_LEN;
            bit_period_reg    <= RESET_BIT_PER;
            data_bits_reg     <= RESET_DATA_BITS;
            invert_reg        <= 1'b0;
            qualify_count_reg <= RESET_QUALIFY;
            loss_timeout_reg  <= RESET_LOSS_TO;
            loss_enable_reg   <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_SAMPLE_BIAS:   sample_bias_reg   <= cfg_data[7:0];
                CFG_DELAY_LENGTH:  delay_length_reg  <= cfg_data[4:0];
                CFG_BIT_PERIOD:    bit_period_reg    <= cfg_data[9:0];
                CFG_DATA_BITS:     data_bits_reg     <= cfg_data[3:0];
                CFG_INVERT:        invert_reg        <= cfg_data[0];
                CFG_QUALIFY_COUNT: qualify_count_reg <= cfg_data[15:0];
                CFG_LOSS_TIMEOUT:  loss_timeout_reg  <= cfg_data;
                CFG_LOSS_ENABLE:   loss_enable_reg   <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    assign dfr_cfg.bit_period    = bit_period_reg;
    assign dfr_cfg.data_bits     = data_bits_reg;
    assign dfr_cfg.qualify_count = qualify_count_reg;
    assign dfr_cfg.loss_timeout  = loss_timeout_reg;
    assign dfr_cfg.loss_enable   = loss_enable_reg;

    // Pipeline handshake
    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign in_accept  = in_valid && in_ready;
    assign s1_is_sample = (action_t'(s1_action_reg) == ACT_SAMPLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
                s1_valid_reg <= 1'b1;
            else if (s1_advance)
                s1_valid_reg <= 1'b0;
            if (s1_advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Stage 1 payload and output register
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_action_reg <= action;
            s1_sample_reg <= sample;
        end
        if (s1_advance)
        begin
            out_corr_reg <= corr;
            out_dfr_reg  <= dfr;
        end
    end

    afskd_delay_line #(
        .DELAY_DEPTH (DELAY_DEPTH)
    ) u_delay (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (in_accept),
        .is_sample    (action_t'(action) == ACT_SAMPLE),
        .sample       (sample),
        .delay_length (delay_length_reg),
        .delayed      (delayed)
    );

    afskd_correlator u_corr (
        .clk             (clk),
        .rst_n           (rst_n),
        .advance         (s1_advance),
        .is_sample       (s1_is_sample),
        .sample          (s1_sample_reg),
        .delayed         (delayed),
        .sample_bias     (sample_bias_reg),
        .invert_polarity (invert_reg),
        .result          (corr)
    );

    afskd_deframer u_dfr (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (s1_advance),
        .action    (s1_action_reg),
        .demod_bit (corr.demod_bit),
        .cfg       (dfr_cfg),
        .result    (dfr)
    );

    // Result ports
    assign out_valid       = out_valid_reg;
    assign byte_valid      = out_dfr_reg.byte_valid;
    assign byte_value      = out_dfr_reg.byte_value;
    assign demod_bit       = out_corr_reg.demod_bit;
    assign carrier_present = out_dfr_reg.carrier_present;
    assign carrier_lost    = out_dfr_reg.carrier_lost;
    assign filter_out      = out_corr_reg.filter_out;

endmodule

// ===== sim/tb_afsk_demodulator_uart_deframer_top.sv =====
// Testbench for afsk_demodulator_uart_deframer_top: shaped tone frames and noise,
// checked transaction by transaction against a scoreboard that predicts every result.
// Depends on afskd_pkg and the RTL under rtl/core.
`timescale 1ns / 100ps

import afskd_pkg::*;

localparam int DELAY_TAPS = 16;

typedef struct packed {
    logic               byte_valid;
    logic [7:0]         byte_value;
    logic               demod_bit;
    logic               carrier_present;
    logic               carrier_lost;
    logic signed [15:0] filter_out;
} rx_result_t;

// Predicts the demodulator and deframer and checks each result in order
class afsk_rx_scoreboard;
    // register copies
    logic [7:0]  bias;
    logic [4:0]  delay_len;
    logic [9:0]  bit_period;
    logic [3:0]  data_bits;
    logic        invert;
    logic [15:0] qualify_count;
    logic [23:0] loss_timeout;
    logic        loss_enable;

    // correlator and deframer state
    logic [7:0]  taps [DELAY_TAPS];
    int          wr_ptr;
    int          prod_q;
    int          filt_q;
    mode_t       mode;
    logic [7:0]  history;
    logic [10:0] ones_count;
    logic [10:0] elapsed;
    logic [3:0]  bit_num;
    logic [7:0]  shifter;
    logic        carrier;
    int unsigned qualify_run;
    logic [23:0] silence;

    rx_result_t  demod_results_due [$];
    int          failures;
    int          chars_seen;
    int          losses_seen;

    function new();
        bias          = RESET_BIAS;
        delay_len     = RESET_DELAY_LEN;
        bit_period    = RESET_BIT_PER;
        data_bits     = RESET_DATA_BITS;
        invert        = 1'b0;
        qualify_count = RESET_QUALIFY;
        loss_timeout  = RESET_LOSS_TO;
        loss_enable   = 1'b0;
        foreach (taps[i]) taps[i] = RESET_BIAS;
        wr_ptr      = 0;
        prod_q      = 0;
        filt_q      = 0;
        mode        = MODE_IDLE;
        history     = '0;
        ones_count  = '0;
        elapsed     = '0;
        bit_num     = '0;
        shifter     = '0;
        carrier     = 1'b0;
        qualify_run = 0;
        silence     = '0;
        failures    = 0;
        chars_seen  = 0;
        losses_seen = 0;
    endfunction

    function void set_reg(cfg_index_t idx, logic [23:0] v);
        case (idx)
            CFG_SAMPLE_BIAS:   bias          = v[7:0];
            CFG_DELAY_LENGTH:  delay_len     = v[4:0];
            CFG_BIT_PERIOD:    bit_period    = v[9:0];
            CFG_DATA_BITS:     data_bits     = v[3:0];
            CFG_INVERT:        invert        = v[0];
            CFG_QUALIFY_COUNT: qualify_count = v[15:0];
            CFG_LOSS_TIMEOUT:  loss_timeout  = v;
            CFG_LOSS_ENABLE:   loss_enable   = v[0];
            default: ;
        endcase
    endfunction

    // bias removed with 8-bit wrap, read as two's complement
    function int centered(logic [7:0] v);
        logic [7:0] d;
        d = v - bias;
        return int'($signed(d));
    endfunction

    // Work out the result of one accepted transaction and queue it
    function void note_accepted(logic [1:0] act, logic [7:0] smp);
        rx_result_t r;
        int         lag;
        int         x;
        int         y;
        logic [7:0] delayed;
        logic       s;
        logic [9:0] half;
        logic [9:0] quarter;
        logic [9:0] eighth;

        r = '0;
        case (action_t'(act))
            ACT_SAMPLE: begin
                // correlator and low-pass
                lag = (delay_len == 0) ? 1 : (delay_len > DELAY_TAPS) ? DELAY_TAPS : delay_len;
                delayed = taps[(wr_ptr + DELAY_TAPS - lag) % DELAY_TAPS];
                x = (centered(smp) * centered(delayed)) >>> 2;
                y = prod_q + x + (filt_q >>> 1);
                prod_q = x;
                filt_q = y;
                taps[wr_ptr] = smp;
                wr_ptr = (wr_ptr + 1) % DELAY_TAPS;
                s = (y > 0) ^ invert;
                r.demod_bit = s;

                ones_count = ones_count + s;
                history    = {history[6:0], s};
                elapsed    = elapsed + 1'b1;
                if (silence != SILENCE_MAX)
                    silence = silence + 1'b1;
                half    = bit_period >> 1;
                quarter = bit_period >> 2;
                eighth  = bit_period >> 3;

                // deframer
                case (mode)
                    MODE_HUNT: begin
                        if (s) begin
                            qualify_run++;
                            if (qualify_run >= qualify_count) begin
                                carrier = 1'b1;
                                mode    = MODE_WAIT;
                                silence = '0;
                            end
                        end else begin
                            qualify_run = 0;
                        end
                    end
                    MODE_WAIT: begin
                        if (history[1:0] == HIST_EDGE) begin
                            mode       = MODE_EDGE;
                            elapsed    = '0;
                            ones_count = '0;
                        end else if (history == HIST_ALL_ONES) begin
                            silence = '0;
                        end
                        if (silence > loss_timeout && loss_enable && loss_timeout != 0) begin
                            carrier = 1'b0;
                            mode    = MODE_LOST;
                            r.carrier_lost = 1'b1;
                        end
                    end
                    MODE_EDGE: begin
                        if (elapsed >= half)
                            mode = (ones_count > eighth) ? MODE_WAIT : MODE_START;
                    end
                    MODE_START: begin
                        if (elapsed >= bit_period) begin
                            if (ones_count > quarter) begin
                                mode = MODE_WAIT;
                            end else begin
                                mode       = MODE_DATA;
                                shifter    = '0;
                                elapsed    = '0;
                                ones_count = '0;
                                bit_num    = '0;
                            end
                        end
                    end
                    MODE_DATA: begin
                        if (elapsed >= bit_period) begin
                            shifter = {(ones_count > half), shifter[7:1]};
                            bit_num = bit_num + 1'b1;
                            if (bit_num < data_bits) begin
                                elapsed = '0;
                            end else begin
                                mode    = MODE_STOP;
                                elapsed = half;
                            end
                            ones_count = '0;
                        end
                    end
                    MODE_STOP: begin
                        if (elapsed >= bit_period) begin
                            if (ones_count > quarter) begin
                                r.byte_valid = 1'b1;
                                r.byte_value = shifter;
                            end
                            mode = MODE_WAIT;
                        end
                    end
                    default: ;
                endcase
            end
            ACT_HUNT: begin
                carrier     = 1'b0;
                mode        = MODE_HUNT;
                qualify_run = 0;
                silence     = '0;
            end
            ACT_WAIT: begin
                carrier = 1'b1;
                mode    = MODE_WAIT;
                silence = '0;
            end
            default: begin
                carrier = 1'b0;
                mode    = MODE_IDLE;
            end
        endcase
        r.carrier_present = carrier;
        r.filter_out      = filt_q[15:0];
        if (r.byte_valid)
            chars_seen++;
        if (r.carrier_lost)
            losses_seen++;
        demod_results_due.push_back(r);
    endfunction

    function bit compare_field(string name, logic signed [31:0] want, logic signed [31:0] got);
        if (want !== got) begin
            // reports are capped, further mismatches only counted
            if (failures < 60)
                $error("%s: expected %0d, got %0d", name, want, got);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function void check_output(rx_result_t got);
        rx_result_t want;
        bit         bad;

        if (demod_results_due.size() == 0) begin
            $error("result transaction with no expectation pending");
            failures++;
            return;
        end
        want = demod_results_due.pop_front();
        bad  = 1'b0;
        bad |= compare_field("byte_valid", want.byte_valid, got.byte_valid);
        bad |= compare_field("byte_value", want.byte_value, got.byte_value);
        bad |= compare_field("demod_bit", want.demod_bit, got.demod_bit);
        bad |= compare_field("carrier_present", want.carrier_present, got.carrier_present);
        bad |= compare_field("carrier_lost", want.carrier_lost, got.carrier_lost);
        bad |= compare_field("filter_out", want.filter_out, got.filter_out);
        if (bad)
            failures++;
    endfunction
endclass

module tb_afsk_demodulator_uart_deframer_top;

    localparam int CYCLE_LIMIT    = 1000000;
    localparam int FRAME_GOOD     = 0;
    localparam int FRAME_GLITCH   = 1;
    localparam int FRAME_BAD_STOP = 2;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         action;
    logic [7:0]         sample;
    logic               out_valid;
    logic               out_ready;
    logic               byte_valid;
    logic [7:0]         byte_value;
    logic               demod_bit;
    logic               carrier_present;
    logic               carrier_lost;
    logic signed [15:0] filter_out;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [23:0]        cfg_data;

    afsk_rx_scoreboard sb;
    int                idle_pct = 14;
    int                items_sent = 0;
    int                settings_run = 0;
    int                cycle_count = 0;
    int                phase_num;
    // recent samples, used to shape the tone for the next one
    logic [7:0]        tone_hist [DELAY_TAPS];
    int                tone_ptr = 0;

    afsk_demodulator_uart_deframer_top #(
        .DELAY_DEPTH(DELAY_TAPS)
    ) u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .action          (action),
        .sample          (sample),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .byte_valid      (byte_valid),
        .byte_value      (byte_value),
        .demod_bit       (demod_bit),
        .carrier_present (carrier_present),
        .carrier_lost    (carrier_lost),
        .filter_out      (filter_out),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver stalls
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= idle_pct);
    end

    // Note accepted inputs first, then check accepted results
    always @(posedge clk)
    begin
        rx_result_t got;
        if (rst_n) begin
            if (in_valid && in_ready)
                sb.note_accepted(action, sample);
            if (out_valid && out_ready) begin
                got.byte_valid      = byte_valid;
                got.byte_value      = byte_value;
                got.demod_bit       = demod_bit;
                got.carrier_present = carrier_present;
                got.carrier_lost    = carrier_lost;
                got.filter_out      = filter_out;
                sb.check_output(got);
            end
        end
    end

    // Watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_afsk_demodulator_uart_deframer_top failed");
        $finish;
    end

    // One input transaction, with random idle cycles ahead of it
    task automatic send_item(action_t act, logic [7:0] smp);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        sample   <= smp;
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    task automatic send_sample(logic [7:0] smp);
        tone_hist[tone_ptr] = smp;
        tone_ptr = (tone_ptr + 1) % DELAY_TAPS;
        send_item(ACT_SAMPLE, smp);
    endtask

    // Samples whose sign repeats (mark) or flips (space) against the delayed
    // sample, so the correlator slices to the wanted bit; a little noise mixed in
    task automatic send_tone(logic bit_val, int n);
        int         lag;
        int         amp;
        logic [7:0] d;
        logic       neg;

        lag = (sb.delay_len == 0) ? 1 : (sb.delay_len > DELAY_TAPS) ? DELAY_TAPS : sb.delay_len;
        repeat (n) begin
            if ($urandom_range(99) < 3) begin
                send_sample(8'($urandom));
            end else begin
                d   = tone_hist[(tone_ptr + DELAY_TAPS - lag) % DELAY_TAPS] - sb.bias;
                neg = d[7] ^ ~(bit_val ^ sb.invert);
                amp = $urandom_range(127, 40);
                send_sample(8'(neg ? sb.bias - amp : sb.bias + amp));
            end
        end
    endtask

    // Mark lead-in, then start bit, data LSB first, stop bit, mark gap; or glitch, mark bit
    task automatic send_frame(logic [15:0] ch, int kind);
        int per;
        int nb;

        per = sb.bit_period;
        nb  = (sb.data_bits == 0) ? 1 : sb.data_bits;
        send_tone(1'b1, per / 2 + $urandom_range(per));
        if (kind == FRAME_GLITCH) begin
            send_tone(1'b0, $urandom_range(per / 4 + 1, 1));
            send_tone(1'b1, per);
        end else begin
            send_tone(1'b0, per);
            for (int i = 0; i < nb; i++)
                send_tone(ch[i], per);
            send_tone(kind != FRAME_BAD_STOP, per);
            send_tone(1'b1, $urandom_range(per, 2));
        end
    endtask

    // Arm the receiver, then a mix of frames, noise and control transactions
    task automatic run_traffic(int frames);
        int pick;
        int qc;

        qc = sb.qualify_count;
        if (qc <= 300) begin
            send_item(ACT_HUNT, 8'($urandom));
            if (qc > 4) begin
                // a broken mark run restarts the qualify count
                send_tone(1'b1, qc / 2);
                send_tone(1'b0, 2);
            end
            send_tone(1'b1, qc + 12);
        end else begin
            send_item(ACT_WAIT, 8'($urandom));
            send_tone(1'b1, 12);
        end
        repeat (frames) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                send_item(ACT_WAIT, 8'($urandom));
            end else if (pick < 12) begin
                send_item(action_t'($urandom_range(3, 1)), 8'($urandom));
                send_item(ACT_WAIT, 8'($urandom));
            end else if (pick < 18) begin
                repeat ($urandom_range(30, 4)) send_sample(8'($urandom));
            end
            if (pick >= 18 && pick < 26)
                send_frame(16'($urandom), FRAME_GLITCH);
            else if (pick >= 26 && pick < 32)
                send_frame(16'($urandom), FRAME_BAD_STOP);
            else
                send_frame(16'($urandom), FRAME_GOOD);
        end
    endtask

    // Wait until every expected result has come back
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.demod_results_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [23:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        sb.set_reg(idx, val);
    endtask

    task automatic configure(logic [7:0] b, logic [4:0] dl, logic [9:0] bp, logic [3:0] db,
                             logic inv, logic [15:0] qc, logic [23:0] lt, logic le);
        drain();
        write_reg(CFG_SAMPLE_BIAS, 24'(b));
        write_reg(CFG_DELAY_LENGTH, 24'(dl));
        write_reg(CFG_BIT_PERIOD, 24'(bp));
        write_reg(CFG_DATA_BITS, 24'(db));
        write_reg(CFG_INVERT, 24'(inv));
        write_reg(CFG_QUALIFY_COUNT, 24'(qc));
        write_reg(CFG_LOSS_TIMEOUT, lt);
        write_reg(CFG_LOSS_ENABLE, 24'(le));
        @(negedge clk);
        cfg_valid <= 1'b0;
        settings_run++;
    endtask

    // Main sequence
    initial
    begin
        sb        = new();
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        action    = ACT_SAMPLE;
        sample    = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_SAMPLE_BIAS;
        cfg_data  = '0;
        foreach (tone_hist[i]) tone_hist[i] = RESET_BIAS;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: sample extremes and every action under reset settings
        send_item(ACT_SAMPLE, 8'h00);
        send_item(ACT_SAMPLE, 8'hFF);
        send_item(ACT_SAMPLE, 8'h80);
        send_item(ACT_SAMPLE, 8'h7F);
        send_item(ACT_SAMPLE, 8'h01);
        send_item(ACT_STOP, 8'hFF);
        send_item(ACT_HUNT, 8'h00);
        send_item(ACT_SAMPLE, 8'h55);
        send_item(ACT_SAMPLE, 8'hAA);
        send_item(ACT_WAIT, 8'h00);
        send_item(ACT_SAMPLE, 8'hFF);
        send_item(ACT_SAMPLE, 8'h00);
        send_item(ACT_SAMPLE, 8'hFF);
        send_item(ACT_SAMPLE, 8'h00);
        send_item(ACT_STOP, 8'h00);

        // Delay of zero, zero data bits, zero qualify, loss never reached
        configure(8'h00, 5'd0, 10'd8, 4'd0, 1'b1, 16'd0, 24'hFF_FFFF, 1'b1);
        run_traffic(1);
        // Delay above depth, short bit period, 15 data bits, zero timeout
        configure(8'hFF, 5'd31, 10'd4, 4'd15, 1'b0, 16'hFFFF, 24'd0, 1'b1);
        run_traffic(1);
        // Longest bit period, one data bit
        configure(8'h80, 5'd16, 10'd1023, 4'd1, 1'b0, 16'd5, 24'd0, 1'b0);
        run_traffic(0);
        // Short loss timeout, no idling on either side
        idle_pct = 0;
        configure(8'h80, 5'd1, 10'd8, 4'd8, 1'b0, 16'd4, 24'd30, 1'b1);
        run_traffic(1);

        // Random settings until enough transactions have gone in
        phase_num = 0;
        while (items_sent < 400) begin
            idle_pct = (phase_num % 5 == 1) ? 0 : 14;
            configure(8'($urandom),
                      5'(($urandom_range(7) == 0) ? $urandom_range(16, 5) : $urandom_range(4, 1)),
                      10'($urandom_range(24, 8)), 4'($urandom_range(8, 1)),
                      1'($urandom_range(1)), 16'($urandom_range(40)),
                      24'($urandom_range(600, 60)), 1'($urandom_range(1)));
            run_traffic(1);
            phase_num++;
        end

        drain();
        repeat (8) @(posedge clk);
        $display("Ran %0d transactions over %0d register settings", items_sent, settings_run);
        $display("Saw %0d characters and %0d carrier losses", sb.chars_seen, sb.losses_seen);
        if (sb.failures == 0 && sb.demod_results_due.size() == 0)
            $display("tb_afsk_demodulator_uart_deframer_top passed");
        else
            $display("tb_afsk_demodulator_uart_deframer_top failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/afskd_pkg.sv
rtl/core/afskd_delay_line.sv
rtl/core/afskd_correlator.sv
rtl/core/afskd_deframer.sv
rtl/core/afsk_demodulator_uart_deframer_top.sv
sim/tb_afsk_demodulator_uart_deframer_top.sv
